// File: design/ledseq_pkg.sv
// Shared types, constants and pattern functions for the LED pattern sequencer.
package ledseq_pkg;

  localparam int unsigned PATTERN_COUNT = 6;
  localparam int unsigned PAT_W = 3;
  localparam int unsigned STEP_W = 4;
  localparam int unsigned MS_W = 16;
  localparam int unsigned LED_W = 8;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [PAT_W-1:0] PAT_WALK_LEFT = 3'd0;
  localparam logic [PAT_W-1:0] PAT_WALK_RIGHT = 3'd1;
  localparam logic [PAT_W-1:0] PAT_FILL_LEFT = 3'd2;
  localparam logic [PAT_W-1:0] PAT_FILL_RIGHT = 3'd3;
  localparam logic [PAT_W-1:0] PAT_OPEN = 3'd4;
  localparam logic [PAT_W-1:0] PAT_CLOSE = 3'd5;

  localparam logic [STEP_W-1:0] LONG_LIMIT = 4'd8;
  localparam logic [STEP_W-1:0] SHORT_LIMIT = 4'd4;

  localparam logic [MS_W-1:0] FAST_RESET = 16'd30;
  localparam logic [MS_W-1:0] SLOW_RESET = 16'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FAST_INTERVAL = 1'b0,
    CFG_SLOW_INTERVAL = 1'b1
  } cfg_reg_e;

  typedef logic [PAT_W-1:0] pattern_t;

  typedef struct packed {
    logic                                  manual_mode;
    pattern_t                              auto_pattern;
    pattern_t                              manual_pattern;
    logic [PATTERN_COUNT-1:0][STEP_W-1:0]  pattern_step;
    logic [MS_W-1:0]                       elapsed_ms;
    logic [LED_W-1:0]                      led;
  } seq_state_t;

  // Next pattern in the fixed order, wrapping after the closing pattern.
  function automatic pattern_t next_pattern(input pattern_t p);
    pattern_t r;
    if (p == PAT_CLOSE) begin
      r = PAT_WALK_LEFT;
    end else begin
      r = p + 3'd1;
    end
    return r;
  endfunction

  // LED byte after one step of pattern p at step s.
  function automatic logic [LED_W-1:0] pattern_leds(input pattern_t p,
                                                    input logic [STEP_W-1:0] s,
                                                    input logic [LED_W-1:0] led);
    logic [LED_W-1:0] r;
    r = '0;
    case (p)
      PAT_WALK_LEFT:  r = 8'h01 << s[2:0];
      PAT_WALK_RIGHT: r = 8'h80 >> s[2:0];
      PAT_FILL_LEFT:  r = led | (8'h01 << s[2:0]);
      PAT_FILL_RIGHT: r = led | (8'h80 >> s[2:0]);
      PAT_OPEN:       r = led | (8'h10 << s[1:0]) | (8'h08 >> s[1:0]);
      PAT_CLOSE:      r = ((8'hf0 >> s[1:0]) & 8'hf0) | ((8'h0f << s[1:0]) & 8'h0f);
      default:        r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: design/ledseq_if.sv
// Valid/ready channel interfaces for the sequencer's input and result transactions.
interface ledseq_in_if;
  logic valid;
  logic ready;
  logic ms_tick;
  logic mode_press;
  logic advance_press;

  modport source (output valid, output ms_tick, output mode_press, output advance_press,
                  input ready);
  modport sink (input valid, input ms_tick, input mode_press, input advance_press,
                output ready);
endinterface

interface ledseq_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] led_bits;
  logic       manual_mode;
  logic [2:0] active_pattern;

  modport source (output valid, output led_bits, output manual_mode, output active_pattern,
                  input ready);
  modport sink (input valid, input led_bits, input manual_mode, input active_pattern,
                output ready);
endinterface

// File: design/led_pattern_sequencer_top.sv
// Top level of the LED pattern sequencer: state, configuration and result registers.
// The sequencer takes one input transaction per clock cycle and returns exactly one result
// transaction for each in the cycle after acceptance; its full state (mode, pattern selectors,
// six step counters, the saturating millisecond count and the LED byte) is updated in that
// single cycle by the next-state logic, and a result register decouples the output channel
// so input is still taken while a result waits, as long as the result is consumed that
// cycle. Register 0 sets the step interval of the shift, fill and closing patterns and
// register 1 that of the opening pattern; write them only while no transaction is pending.
module led_pattern_sequencer_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [ledseq_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ledseq_pkg::MS_W-1:0]        cfg_data_i,
  ledseq_in_if.sink                          in_i,
  ledseq_out_if.source                       out_o
);
  import ledseq_pkg::*;

  seq_state_t        state_q, state_d;
  logic [MS_W-1:0]   fast_interval_q, slow_interval_q;
  pattern_t          sel;
  logic              out_valid_q;
  logic [LED_W-1:0]  led_q;
  logic              mode_q;
  pattern_t          pattern_q;
  logic              accept;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept = in_i.valid && in_i.ready;

  ledseq_step u_step (
    .state_i          (state_q),
    .fast_interval_i  (fast_interval_q),
    .slow_interval_i  (slow_interval_q),
    .ms_tick_i        (in_i.ms_tick),
    .mode_press_i     (in_i.mode_press),
    .advance_press_i  (in_i.advance_press),
    .state_o          (state_d),
    .active_pattern_o (sel)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_interval_q <= FAST_RESET;
      slow_interval_q <= SLOW_RESET;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_FAST_INTERVAL: fast_interval_q <= cfg_data_i;
        CFG_SLOW_INTERVAL: slow_interval_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      led_q <= state_d.led;
      mode_q <= state_d.manual_mode;
      pattern_q <= sel;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.led_bits = led_q;
  assign out_o.manual_mode = mode_q;
  assign out_o.active_pattern = pattern_q;

endmodule

// File: design/ledseq_step.sv
// Next-state logic of the sequencer for one input transaction.
module ledseq_step (
  input  ledseq_pkg::seq_state_t        state_i,
  input  logic [ledseq_pkg::MS_W-1:0]   fast_interval_i,
  input  logic [ledseq_pkg::MS_W-1:0]   slow_interval_i,
  input  logic                          ms_tick_i,
  input  logic                          mode_press_i,
  input  logic                          advance_press_i,
  output ledseq_pkg::seq_state_t        state_o,
  output ledseq_pkg::pattern_t          active_pattern_o
);
  import ledseq_pkg::*;

  logic [MS_W-1:0]   elapsed;
  logic              mode;
  pattern_t          manual_pat;
  pattern_t          sel;
  logic [MS_W-1:0]   interval;
  logic [STEP_W-1:0] limit;
  logic [STEP_W-1:0] step;
  logic              fire;

  always_comb begin
    state_o = state_i;

    // The millisecond count saturates rather than wrapping.
    elapsed = state_i.elapsed_ms;
    if (ms_tick_i && (state_i.elapsed_ms != '1)) begin
      elapsed = state_i.elapsed_ms + 16'd1;
    end

    mode = state_i.manual_mode ^ mode_press_i;
    manual_pat = state_i.manual_pattern;
    if (mode && advance_press_i) begin
      manual_pat = next_pattern(state_i.manual_pattern);
    end
    sel = mode ? manual_pat : state_i.auto_pattern;

    interval = (sel == PAT_OPEN) ? slow_interval_i : fast_interval_i;
    limit = (sel < PAT_OPEN) ? LONG_LIMIT : SHORT_LIMIT;

    step = '0;
    case (sel)
      PAT_WALK_LEFT, PAT_WALK_RIGHT, PAT_FILL_LEFT,
      PAT_FILL_RIGHT, PAT_OPEN, PAT_CLOSE: step = state_i.pattern_step[sel];
      default: step = '0;
    endcase

    fire = (elapsed >= interval);

    state_o.manual_mode = mode;
    state_o.manual_pattern = manual_pat;
    state_o.elapsed_ms = elapsed;

    if (fire) begin
      state_o.elapsed_ms = '0;
      if (step >= limit) begin
        // End of the pattern: blank, restart its steps and move on in auto mode.
        state_o.pattern_step[sel] = '0;
        state_o.led = '0;
        if (!mode) begin
          state_o.auto_pattern = next_pattern(state_i.auto_pattern);
        end
      end else begin
        state_o.led = pattern_leds(sel, step, state_i.led);
        state_o.pattern_step[sel] = step + 4'd1;
      end
    end

    active_pattern_o = mode ? manual_pat : state_o.auto_pattern;
  end

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the LED pattern sequencer, with its own model of the sequencer.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ledseq_pkg::*;

  localparam bit AUTO = 1'b0;
  localparam bit MANUAL = 1'b1;
  localparam int TYPED_ROWS = 13;
  localparam int TICK_RUN_ITEMS = 30;

  typedef struct packed {
    logic tick;
    logic mode_press;
    logic advance_press;
  } button_item_t;

  typedef struct packed {
    logic [LED_W-1:0] leds;
    logic             manual;
    pattern_t         pattern;
  } led_frame_t;

  typedef struct {
    button_item_t stim;
    bit           typed;
    led_frame_t   want;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [MS_W-1:0] cfg_data;

  ledseq_in_if in_ch ();
  ledseq_out_if out_ch ();

  led_pattern_sequencer_top DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_ch.sink),
    .out_o      (out_ch.source)
  );

  always #2 clk = ~clk;

  // Model of the sequencer state and its interval registers.
  logic             manual_sel;
  pattern_t         auto_sel;
  pattern_t         manual_pat;
  logic [STEP_W-1:0] step_count [PATTERN_COUNT];
  logic [MS_W-1:0]  ms_elapsed;
  logic [LED_W-1:0] led_state;
  logic [MS_W-1:0]  fast_ms;
  logic [MS_W-1:0]  slow_ms;

  led_frame_t pending_frames[$];
  int mismatches = 0;
  int frames_checked = 0;
  int items_sent = 0;
  int patterns_finished = 0;
  int hold_cycles = 0;
  bit bursts_on = 1'b0;

  // Applies one input transaction to the model and returns the LED frame it produces.
  function automatic led_frame_t next_led_frame(input button_item_t it);
    led_frame_t f;
    pattern_t p;
    logic [MS_W-1:0] interval;
    logic [STEP_W-1:0] s;
    logic [STEP_W-1:0] last;
    if (it.tick && ms_elapsed != '1) ms_elapsed = ms_elapsed + 1'b1;
    if (it.mode_press) manual_sel = ~manual_sel;
    if (manual_sel && it.advance_press) begin
      manual_pat = (manual_pat == PAT_CLOSE) ? PAT_WALK_LEFT : manual_pat + 3'd1;
    end
    p = manual_sel ? manual_pat : auto_sel;
    interval = (p == PAT_OPEN) ? slow_ms : fast_ms;
    last = (p == PAT_OPEN || p == PAT_CLOSE) ? SHORT_LIMIT : LONG_LIMIT;
    if (ms_elapsed >= interval) begin
      ms_elapsed = '0;
      s = step_count[p];
      if (s >= last) begin
        // The pattern has run out: blank the row and, in auto mode, move on.
        step_count[p] = '0;
        led_state = '0;
        patterns_finished++;
        if (!manual_sel) begin
          auto_sel = (auto_sel == PAT_CLOSE) ? PAT_WALK_LEFT : auto_sel + 3'd1;
        end
      end else begin
        case (p)
          PAT_WALK_LEFT:  led_state = 8'h01 << s;
          PAT_WALK_RIGHT: led_state = 8'h80 >> s;
          PAT_FILL_LEFT:  led_state = led_state | (8'h01 << s);
          PAT_FILL_RIGHT: led_state = led_state | (8'h80 >> s);
          PAT_OPEN:       led_state = led_state | (8'h10 << s) | (8'h08 >> s);
          PAT_CLOSE:      led_state = ((8'hf0 >> s) & 8'hf0) | ((8'h0f << s) & 8'h0f);
          default:        led_state = '0;
        endcase
        step_count[p] = s + 1'b1;
      end
    end
    f.leds = led_state;
    f.manual = manual_sel;
    f.pattern = manual_sel ? manual_pat : auto_sel;
    return f;
  endfunction

  function automatic button_item_t random_item();
    button_item_t it;
    it.tick = ($urandom_range(0, 3) != 0);
    it.mode_press = ($urandom_range(0, 11) == 0);
    it.advance_press = ($urandom_range(0, 3) == 0);
    return it;
  endfunction

  function automatic directed_row_t row(input bit t, input bit m, input bit a);
    directed_row_t r;
    r.stim.tick = t;
    r.stim.mode_press = m;
    r.stim.advance_press = a;
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic directed_row_t typed_row(input bit t, input bit m, input bit a,
                                              input logic [LED_W-1:0] leds, input bit manual,
                                              input pattern_t pat);
    directed_row_t r;
    r = row(t, m, a);
    r.typed = 1'b1;
    r.want.leds = leds;
    r.want.manual = manual;
    r.want.pattern = pat;
    return r;
  endfunction

  // Called at a rising edge; returns at the edge where the transaction is accepted.
  task automatic send_item(input button_item_t it, input bit typed, input led_frame_t want);
    led_frame_t predicted;
    in_ch.valid <= 1'b1;
    in_ch.ms_tick <= it.tick;
    in_ch.mode_press <= it.mode_press;
    in_ch.advance_press <= it.advance_press;
    do @(posedge clk); while (!in_ch.ready);
    predicted = next_led_frame(it);
    pending_frames.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  task automatic sender_gap();
    if (bursts_on && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Writes the fast interval register, then the slow one; only called while idle.
  task automatic set_intervals(input logic [MS_W-1:0] fast, input logic [MS_W-1:0] slow);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_FAST_INTERVAL;
    cfg_data <= fast;
    @(posedge clk);
    cfg_idx <= CFG_SLOW_INTERVAL;
    cfg_data <= slow;
    @(posedge clk);
    cfg_we <= 1'b0;
    fast_ms = fast;
    slow_ms = slow;
  endtask

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) begin
      send_item(random_item(), 1'b0, '0);
      sender_gap();
    end
  endtask

  initial begin : result_checker
    led_frame_t want;
    int stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        if (pending_frames.size() == 0) begin
          $error("result transaction with nothing expected: led_bits %h", out_ch.led_bits);
          mismatches++;
        end else begin
          want = pending_frames.pop_front();
          frames_checked++;
          if (out_ch.led_bits !== want.leds) begin
            $error("led_bits: expected %h, got %h", want.leds, out_ch.led_bits);
            mismatches++;
          end
          if (out_ch.manual_mode !== want.manual) begin
            $error("manual_mode: expected %0d, got %0d", want.manual, out_ch.manual_mode);
            mismatches++;
          end
          if (out_ch.active_pattern !== want.pattern) begin
            $error("active_pattern: expected %0d, got %0d", want.pattern,
                   out_ch.active_pattern);
            mismatches++;
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (bursts_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 13);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    directed_row_t directed_table[$];
    button_item_t tick_only;
    cfg_we <= 1'b0;
    cfg_idx <= CFG_FAST_INTERVAL;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.ms_tick <= 1'b0;
    in_ch.mode_press <= 1'b0;
    in_ch.advance_press <= 1'b0;

    fast_ms = FAST_RESET;
    slow_ms = SLOW_RESET;
    manual_sel = AUTO;
    auto_sel = PAT_WALK_LEFT;
    manual_pat = PAT_WALK_LEFT;
    foreach (step_count[k]) step_count[k] = '0;
    ms_elapsed = '0;
    led_state = '0;

    // With the reset intervals nothing steps here, so the frames can be written down.
    directed_table.push_back(typed_row(0, 0, 0, 8'h00, AUTO, PAT_WALK_LEFT));
    directed_table.push_back(typed_row(1, 0, 0, 8'h00, AUTO, PAT_WALK_LEFT));
    directed_table.push_back(typed_row(0, 0, 1, 8'h00, AUTO, PAT_WALK_LEFT));
    directed_table.push_back(typed_row(0, 1, 0, 8'h00, MANUAL, PAT_WALK_LEFT));
    directed_table.push_back(typed_row(0, 0, 1, 8'h00, MANUAL, PAT_WALK_RIGHT));
    directed_table.push_back(typed_row(1, 0, 1, 8'h00, MANUAL, PAT_FILL_LEFT));
    directed_table.push_back(typed_row(0, 0, 1, 8'h00, MANUAL, PAT_FILL_RIGHT));
    directed_table.push_back(typed_row(0, 0, 1, 8'h00, MANUAL, PAT_OPEN));
    directed_table.push_back(typed_row(0, 0, 1, 8'h00, MANUAL, PAT_CLOSE));
    directed_table.push_back(typed_row(0, 0, 1, 8'h00, MANUAL, PAT_WALK_LEFT));
    directed_table.push_back(typed_row(0, 1, 1, 8'h00, AUTO, PAT_WALK_LEFT));
    directed_table.push_back(typed_row(1, 1, 1, 8'h00, MANUAL, PAT_WALK_RIGHT));
    directed_table.push_back(typed_row(0, 1, 0, 8'h00, AUTO, PAT_WALK_LEFT));
    // From here on both intervals are set to one and the model judges the frames.
    directed_table.push_back(row(1, 0, 0));
    directed_table.push_back(row(1, 0, 0));
    directed_table.push_back(row(0, 1, 0));
    directed_table.push_back(row(1, 0, 1));
    directed_table.push_back(row(1, 0, 1));
    directed_table.push_back(row(1, 0, 1));
    directed_table.push_back(row(1, 0, 1));
    directed_table.push_back(row(1, 0, 1));
    directed_table.push_back(row(1, 0, 0));
    directed_table.push_back(row(0, 0, 0));
    directed_table.push_back(row(1, 1, 0));
    directed_table.push_back(row(1, 0, 0));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    bursts_on = 1'b1;

    for (int i = 0; i < directed_table.size(); i++) begin
      if (i == TYPED_ROWS) begin
        drain();
        set_intervals(16'd1, 16'd1);
      end
      send_item(directed_table[i].stim, directed_table[i].typed, directed_table[i].want);
      sender_gap();
    end

    run_random(90);
    drain();
    set_intervals(16'd2, 16'd3);
    run_random(50);
    // The sender waits here until every outstanding result has been returned.
    drain();
    run_random(50);

    // A zero interval makes the running pattern step on every transaction.
    drain();
    set_intervals(16'd0, 16'd0);
    run_random(45);
    // Long receiver hold-off while transactions keep coming, so the input backs up.
    hold_cycles = 60;
    repeat (24) send_item(random_item(), 1'b0, '0);
    run_random(45);

    drain();
    bursts_on = 1'b0;
    set_intervals(16'($urandom_range(1, 4)), 16'($urandom_range(1, 4)));
    run_random(80);

    drain();
    bursts_on = 1'b1;
    set_intervals(FAST_RESET, SLOW_RESET);
    run_random(60);

    drain();
    set_intervals(16'd3, 16'd1);
    run_random(60);

    // Closing stretch without idling: at the largest interval a short tick run never steps.
    drain();
    bursts_on = 1'b0;
    set_intervals(16'hffff, 16'hffff);
    tick_only = '0;
    tick_only.tick = 1'b1;
    repeat (TICK_RUN_ITEMS) send_item(tick_only, 1'b0, '0);

    drain();
    repeat (4) @(posedge clk);
    $display("Run covered %0d input transactions and %0d checked results, %0d pattern ends.",
             items_sent, frames_checked, patterns_finished);
    $display("Intervals went from 0 to 65535 in auto and manual mode, with stalls both ways.");
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Timeout: %0d results still outstanding.", pending_frames.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: filelist.f
design/ledseq_pkg.sv
design/ledseq_if.sv
design/ledseq_step.sv
design/led_pattern_sequencer_top.sv
tb/tb_top.sv
